@@ rtl/core/ccwg_pkg.sv @@
// Shared types, widths, angle constants and sequencer codes for the
// carrot-chase guidance block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ccwg_pkg;

    localparam int CW = 44;   // CORDIC x/y width
    localparam int ZW = 22;   // angle width, radians * 65536
    localparam int AW = 52;   // multiply accumulator width
    localparam int NW = 36;   // square root operand width
    localparam int RW = 18;   // square root result width
    localparam int DEF_NUM_WAYPOINTS = 4;

    localparam logic signed [ZW-1:0] ANG_PI      = 22'sd205887;
    localparam logic signed [ZW-1:0] ANG_TWO_PI  = 22'sd411775;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 22'sd102944;
    localparam logic signed [CW-1:0] INV_GAIN    = 44'sd652032874;

    localparam logic [2:0] CFG_WP0       = 3'd0;
    localparam logic [2:0] CFG_WP1       = 3'd1;
    localparam logic [2:0] CFG_WP2       = 3'd2;
    localparam logic [2:0] CFG_WP3       = 3'd3;
    localparam logic [2:0] CFG_LOOKAHEAD = 3'd4;
    localparam logic [2:0] CFG_GAIN      = 3'd5;
    localparam logic [2:0] CFG_SPEED     = 3'd6;
    localparam logic [2:0] CFG_RADIUS    = 3'd7;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_t;

    typedef struct packed {
        logic        [15:0] linear_speed;
        logic signed [15:0] turn_rate;
        logic               reached;
        logic        [1:0]  segment;
    } out_t;

    // Micro-ops in program order; counted through, arrival skips to OP_OUT.
    typedef enum logic [4:0] {
        OP_CAP, OP_M_RAD, OP_M_AX, OP_M_AY, OP_ARR, OP_M_BX, OP_M_BY, OP_SQRT,
        OP_AT_U, OP_AT_T, OP_SC_B, OP_M_R, OP_DIST, OP_SC_T, OP_M_CX, OP_CX,
        OP_M_CY, OP_CY, OP_AT_H, OP_M_Q1, OP_M_Q2, OP_QY, OP_M_Q3, OP_M_Q4,
        OP_M_Q5, OP_M_Q6, OP_AT_Y, OP_M_G, OP_FIN, OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic issue;
    } cmd_t;

    typedef struct packed {
        logic arrive;
        logic done;
        logic busy;
    } stat_t;

    function automatic logic is_cordic(input op_t op);
        return op == OP_AT_U || op == OP_AT_T || op == OP_SC_B || op == OP_SC_T ||
               op == OP_AT_H || op == OP_AT_Y;
    endfunction

    function automatic logic is_unit(input op_t op);
        return is_cordic(op) || op == OP_SQRT;
    endfunction

    function automatic logic is_vect(input op_t op);
        return op == OP_AT_U || op == OP_AT_T || op == OP_AT_H || op == OP_AT_Y;
    endfunction

    function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] k);
        logic signed [ZW-1:0] v;
        case (k)
            4'd0:  v = 22'sd51472;
            4'd1:  v = 22'sd30385;
            4'd2:  v = 22'sd16055;
            4'd3:  v = 22'sd8150;
            4'd4:  v = 22'sd4091;
            4'd5:  v = 22'sd2047;
            4'd6:  v = 22'sd1024;
            4'd7:  v = 22'sd512;
            4'd8:  v = 22'sd256;
            4'd9:  v = 22'sd128;
            4'd10: v = 22'sd64;
            4'd11: v = 22'sd32;
            4'd12: v = 22'sd16;
            4'd13: v = 22'sd8;
            4'd14: v = 22'sd4;
            default: v = 22'sd2;
        endcase
        return v;
    endfunction

    // single conditional step of 2*pi
    function automatic logic signed [ZW-1:0] wrap_ang(input logic signed [ZW-1:0] a);
        logic signed [ZW-1:0] r;
        if (a > ANG_PI)
            r = a - ANG_TWO_PI;
        else if (a < -ANG_PI)
            r = a + ANG_TWO_PI;
        else
            r = a;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/ccwg_cordic.sv @@
// Iterative CORDIC, one micro-rotation per cycle, vectoring (atan2) and
// rotation (sin/cos) modes. Depends on ccwg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ccwg_cordic (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic                             vect,
    input  wire logic signed [ccwg_pkg::CW-1:0]   x_in,
    input  wire logic signed [ccwg_pkg::CW-1:0]   y_in,
    input  wire logic signed [ccwg_pkg::ZW-1:0]   z_in,
    output logic                                  busy,
    output logic                                  done,
    output logic signed [ccwg_pkg::CW-1:0]        x_out,
    output logic signed [ccwg_pkg::CW-1:0]        y_out,
    output logic signed [ccwg_pkg::ZW-1:0]        z_out
);
    logic signed [ccwg_pkg::CW-1:0] x_reg, y_reg, xs, ys;
    logic signed [ccwg_pkg::ZW-1:0] z_reg, at;
    logic [3:0] k_reg;
    logic busy_reg, done_reg, vect_reg, neg_reg, zero_reg, up;

    assign xs = x_reg >>> k_reg;
    assign ys = y_reg >>> k_reg;
    assign at = ccwg_pkg::atan_lut(k_reg);
    // rotate towards the axis (vectoring) or towards zero residual angle
    assign up = vect_reg ? !(y_reg > 0) : (z_reg >= 0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                k_reg    <= 4'd0;
                vect_reg <= vect;
                zero_reg <= (x_in == '0) && (y_in == '0);
                neg_reg  <= 1'b0;
                if (vect) begin
                    if (x_in < 0) begin
                        x_reg <= -x_in;
                        y_reg <= -y_in;
                        z_reg <= (y_in >= 0) ? ccwg_pkg::ANG_PI : -ccwg_pkg::ANG_PI;
                    end else begin
                        x_reg <= x_in;
                        y_reg <= y_in;
                        z_reg <= '0;
                    end
                end else begin
                    x_reg <= ccwg_pkg::INV_GAIN;
                    y_reg <= '0;
                    if (z_in > ccwg_pkg::ANG_HALF_PI) begin
                        z_reg   <= z_in - ccwg_pkg::ANG_PI;
                        neg_reg <= 1'b1;
                    end else if (z_in < -ccwg_pkg::ANG_HALF_PI) begin
                        z_reg   <= z_in + ccwg_pkg::ANG_PI;
                        neg_reg <= 1'b1;
                    end else begin
                        z_reg <= z_in;
                    end
                end
            end else if (busy_reg) begin
                if (up) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                k_reg <= k_reg + 4'd1;
                if (k_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign x_out = neg_reg ? -x_reg : x_reg;
    assign y_out = neg_reg ? -y_reg : y_reg;
    assign z_out = zero_reg ? '0 : ccwg_pkg::wrap_ang(z_reg);
endmodule
`default_nettype wire

@@ rtl/core/ccwg_isqrt.sv @@
// Floor integer square root, two operand bits per cycle.
// Depends on ccwg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ccwg_isqrt (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [ccwg_pkg::NW-1:0]  n_in,
    output logic                          busy,
    output logic                          done,
    output logic [ccwg_pkg::RW-1:0]       root
);
    logic [ccwg_pkg::NW-1:0] n_reg, res_reg, bit_reg, trial;
    logic busy_reg, done_reg;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                n_reg    <= n_in;
                res_reg  <= '0;
                bit_reg  <= ccwg_pkg::NW'(1) << (ccwg_pkg::NW - 2);
            end else if (busy_reg) begin
                if (n_reg >= trial) begin
                    n_reg   <= n_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg == ccwg_pkg::NW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = res_reg[ccwg_pkg::RW-1:0];
endmodule
`default_nettype wire

@@ rtl/core/ccwg_ctrl.sv @@
// Sequencer: steps the datapath through the micro-op program, waits on
// the CORDIC and square root units, owns the handshakes. Depends on ccwg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ccwg_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire ccwg_pkg::stat_t stat,
    output ccwg_pkg::cmd_t       cmd
);
    typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_WAIT, ST_OUT} state_t;

    state_t          state_reg;
    ccwg_pkg::op_t   op_reg, op_inc;
    logic            m_valid_reg, out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign op_inc   = ccwg_pkg::op_t'(op_reg + 5'd1);

    always_comb begin
        cmd.op    = op_reg;
        cmd.issue = 1'b0;
        case (state_reg)
            ST_IDLE: cmd.issue = s_valid;
            ST_STEP: cmd.issue = 1'b1;
            ST_OUT:  cmd.issue = out_free;
            default: cmd.issue = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= ccwg_pkg::OP_CAP;
            m_valid_reg <= 1'b0;
        end else begin
            // a new word replaces one taken in the same cycle
            if (state_reg == ST_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= op_inc;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (ccwg_pkg::is_unit(op_reg)) begin
                        state_reg <= ST_WAIT;
                    end else if ((op_reg == ccwg_pkg::OP_ARR && stat.arrive) ||
                                 op_reg == ccwg_pkg::OP_FIN) begin
                        op_reg    <= ccwg_pkg::OP_OUT;
                        state_reg <= ST_OUT;
                    end else begin
                        op_reg <= op_inc;
                    end
                end
                ST_WAIT: begin
                    if (stat.done) begin
                        op_reg    <= op_inc;
                        state_reg <= ST_STEP;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        op_reg    <= ccwg_pkg::OP_CAP;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
endmodule
`default_nettype wire

@@ rtl/core/ccwg_dp.sv @@
// Datapath: settings registers, segment index, shared multiplier and
// accumulator, CORDIC and square root units, output word register.
// Depends on ccwg_pkg, ccwg_cordic, ccwg_isqrt.
`timescale 1ns / 1ps
`default_nettype none
module ccwg_dp #(
    parameter int NUM_WAYPOINTS = ccwg_pkg::DEF_NUM_WAYPOINTS
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire ccwg_pkg::in_t   s_data,
    output ccwg_pkg::out_t       m_data,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [31:0]     cfg_wdata,
    input  wire ccwg_pkg::cmd_t  cmd,
    output ccwg_pkg::stat_t      stat
);
    localparam int CW = ccwg_pkg::CW;
    localparam int ZW = ccwg_pkg::ZW;
    localparam int AW = ccwg_pkg::AW;

    typedef enum logic [1:0] {ACC_NONE, ACC_SET, ACC_ADD, ACC_SUB} acc_op_t;

    logic [31:0] wp_reg [4];
    logic [15:0] look_reg, gain_reg, speed_reg, rad_reg;
    logic [1:0]  seg_reg, j_reg;

    logic signed [15:0] px_reg, py_reg, qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [15:0] xi_reg, yi_reg, xj_reg, yj_reg;
    logic signed [AW-1:0] acc_reg, t_reg;
    logic signed [ZW-1:0] theta_u_reg, theta_reg, head_reg, yaw_reg;
    logic signed [31:0] cb_reg, ct_reg, st_reg;
    logic signed [CW-1:0] vy_reg;
    logic [ccwg_pkg::RW-1:0] ru_reg;
    logic signed [19:0] dist_reg;
    logic signed [23:0] cx_reg, cy_reg;
    logic signed [15:0] turn_reg;
    logic arrived_reg;
    ccwg_pkg::out_t out_reg;

    // segment end points from the current index
    logic [2:0] i3, j3;
    logic [1:0] i_sel, j_sel;
    always_comb begin
        i3 = {1'b0, seg_reg};
        if (i3 >= 3'(NUM_WAYPOINTS))
            i3 = 3'd0;
        j3 = (i3 + 3'd1 >= 3'(NUM_WAYPOINTS)) ? 3'd0 : i3 + 3'd1;
        i_sel = i3[1:0];
        j_sel = j3[1:0];
    end

    // shared multiplier
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [ZW-1:0] err;
    acc_op_t mmode;
    assign err  = ccwg_pkg::wrap_ang(head_reg - yaw_reg);
    assign prod = ma * mb;

    always_comb begin
        ma = '0;
        mb = '0;
        mmode = ACC_NONE;
        case (cmd.op)
            ccwg_pkg::OP_M_RAD: begin
                ma = $signed({16'd0, rad_reg}); mb = $signed({16'd0, rad_reg});
            end
            ccwg_pkg::OP_M_AX: begin
                ma = 32'(17'(px_reg) - 17'(xj_reg)); mb = ma; mmode = ACC_SET;
            end
            ccwg_pkg::OP_M_AY: begin
                ma = 32'(17'(py_reg) - 17'(yj_reg)); mb = ma; mmode = ACC_ADD;
            end
            ccwg_pkg::OP_M_BX: begin
                ma = 32'(17'(px_reg) - 17'(xi_reg)); mb = ma; mmode = ACC_SET;
            end
            ccwg_pkg::OP_M_BY: begin
                ma = 32'(17'(py_reg) - 17'(yi_reg)); mb = ma; mmode = ACC_ADD;
            end
            ccwg_pkg::OP_M_R: begin
                ma = $signed({14'd0, ru_reg}); mb = cb_reg; mmode = ACC_SET;
            end
            ccwg_pkg::OP_M_CX: begin
                ma = 32'(dist_reg); mb = ct_reg; mmode = ACC_SET;
            end
            ccwg_pkg::OP_M_CY: begin
                ma = 32'(dist_reg); mb = st_reg; mmode = ACC_SET;
            end
            ccwg_pkg::OP_M_Q1: begin
                ma = 32'(qw_reg); mb = 32'(qz_reg); mmode = ACC_SET;
            end
            ccwg_pkg::OP_M_Q2: begin
                ma = 32'(qx_reg); mb = 32'(qy_reg); mmode = ACC_ADD;
            end
            ccwg_pkg::OP_M_Q3: begin
                ma = 32'(qw_reg); mb = ma; mmode = ACC_SET;
            end
            ccwg_pkg::OP_M_Q4: begin
                ma = 32'(qx_reg); mb = ma; mmode = ACC_ADD;
            end
            ccwg_pkg::OP_M_Q5: begin
                ma = 32'(qy_reg); mb = ma; mmode = ACC_SUB;
            end
            ccwg_pkg::OP_M_Q6: begin
                ma = 32'(qz_reg); mb = ma; mmode = ACC_SUB;
            end
            ccwg_pkg::OP_M_G: begin
                ma = $signed({16'd0, gain_reg}); mb = 32'(err); mmode = ACC_SET;
            end
            default: mmode = ACC_NONE;
        endcase
    end

    // CORDIC operand selection; positions are scaled by 2^14 first
    logic signed [CW-1:0] c_xin, c_yin, c_xo, c_yo;
    logic signed [ZW-1:0] c_zin, c_zo;
    logic c_busy, c_done, q_busy, q_done;
    logic [ccwg_pkg::RW-1:0] q_root;

    always_comb begin
        c_xin = '0;
        c_yin = '0;
        c_zin = '0;
        case (cmd.op)
            ccwg_pkg::OP_AT_U: begin
                c_xin = CW'(17'(xi_reg) - 17'(px_reg)) <<< 14;
                c_yin = CW'(17'(yi_reg) - 17'(py_reg)) <<< 14;
            end
            ccwg_pkg::OP_AT_T: begin
                c_xin = CW'(17'(xj_reg) - 17'(xi_reg)) <<< 14;
                c_yin = CW'(17'(yj_reg) - 17'(yi_reg)) <<< 14;
            end
            ccwg_pkg::OP_AT_H: begin
                c_xin = CW'(25'(cx_reg) - 25'(px_reg)) <<< 14;
                c_yin = CW'(25'(cy_reg) - 25'(py_reg)) <<< 14;
            end
            ccwg_pkg::OP_AT_Y: begin
                c_xin = CW'(acc_reg);
                c_yin = vy_reg;
            end
            ccwg_pkg::OP_SC_B: c_zin = ccwg_pkg::wrap_ang(theta_reg - theta_u_reg);
            ccwg_pkg::OP_SC_T: c_zin = theta_reg;
            default: c_zin = '0;
        endcase
    end

    ccwg_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.issue && ccwg_pkg::is_cordic(cmd.op)),
        .vect    (ccwg_pkg::is_vect(cmd.op)),
        .x_in    (c_xin),
        .y_in    (c_yin),
        .z_in    (c_zin),
        .busy    (c_busy),
        .done    (c_done),
        .x_out   (c_xo),
        .y_out   (c_yo),
        .z_out   (c_zo)
    );

    ccwg_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.issue && cmd.op == ccwg_pkg::OP_SQRT),
        .n_in    (acc_reg[ccwg_pkg::NW-1:0]),
        .busy    (q_busy),
        .done    (q_done),
        .root    (q_root)
    );

    logic signed [AW-1:0] sh30, sh16;
    assign sh30 = acc_reg >>> 30;
    assign sh16 = acc_reg >>> 16;

    // settings registers and segment index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg[0] <= 32'd67109248;
            wp_reg[1] <= 32'd4244636032;
            wp_reg[2] <= 32'd4244700800;
            wp_reg[3] <= 32'd67174016;
            look_reg  <= 16'd128;
            gain_reg  <= 16'd256;
            speed_reg <= 16'd51;
            rad_reg   <= 16'd26;
            seg_reg   <= 2'd0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ccwg_pkg::CFG_WP0, ccwg_pkg::CFG_WP1,
                    ccwg_pkg::CFG_WP2, ccwg_pkg::CFG_WP3: wp_reg[cfg_index[1:0]] <= cfg_wdata;
                    ccwg_pkg::CFG_LOOKAHEAD: look_reg  <= cfg_wdata[15:0];
                    ccwg_pkg::CFG_GAIN:      gain_reg  <= cfg_wdata[15:0];
                    ccwg_pkg::CFG_SPEED:     speed_reg <= cfg_wdata[15:0];
                    ccwg_pkg::CFG_RADIUS:    rad_reg   <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (cmd.issue && cmd.op == ccwg_pkg::OP_OUT && arrived_reg)
                seg_reg <= j_reg;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            case (mmode)
                ACC_SET: acc_reg <= AW'(prod);
                ACC_ADD: acc_reg <= acc_reg + AW'(prod);
                ACC_SUB: acc_reg <= acc_reg - AW'(prod);
                default: ;
            endcase
            case (cmd.op)
                ccwg_pkg::OP_CAP: begin
                    px_reg <= s_data.pos_x;
                    py_reg <= s_data.pos_y;
                    qx_reg <= s_data.quat_x;
                    qy_reg <= s_data.quat_y;
                    qz_reg <= s_data.quat_z;
                    qw_reg <= s_data.quat_w;
                    xi_reg <= wp_reg[i_sel][31:16];
                    yi_reg <= wp_reg[i_sel][15:0];
                    xj_reg <= wp_reg[j_sel][31:16];
                    yj_reg <= wp_reg[j_sel][15:0];
                    j_reg  <= j_sel;
                end
                ccwg_pkg::OP_M_RAD: t_reg <= AW'(prod);
                ccwg_pkg::OP_ARR:   arrived_reg <= stat.arrive;
                ccwg_pkg::OP_DIST:  dist_reg <= 20'(sh30) + 20'(look_reg);
                ccwg_pkg::OP_CX:    cx_reg <= 24'(sh30) + 24'(xi_reg);
                ccwg_pkg::OP_CY:    cy_reg <= 24'(sh30) + 24'(yi_reg);
                // doubled cross term can need 34 bits with full-range components
                ccwg_pkg::OP_QY:    vy_reg <= CW'(acc_reg) <<< 1;
                ccwg_pkg::OP_FIN: begin
                    if (sh16 > AW'(32767))
                        turn_reg <= 16'sh7fff;
                    else if (sh16 < -AW'(32768))
                        turn_reg <= 16'sh8000;
                    else
                        turn_reg <= 16'(sh16);
                end
                ccwg_pkg::OP_OUT: begin
                    if (arrived_reg) begin
                        out_reg.linear_speed <= '0;
                        out_reg.turn_rate    <= '0;
                        out_reg.reached      <= 1'b1;
                        out_reg.segment      <= j_reg;
                    end else begin
                        out_reg.linear_speed <= speed_reg;
                        out_reg.turn_rate    <= turn_reg;
                        out_reg.reached      <= 1'b0;
                        out_reg.segment      <= seg_reg;
                    end
                end
                default: ;
            endcase
        end
        if (c_done) begin
            case (cmd.op)
                ccwg_pkg::OP_AT_U: theta_u_reg <= c_zo;
                ccwg_pkg::OP_AT_T: theta_reg   <= c_zo;
                ccwg_pkg::OP_AT_H: head_reg    <= c_zo;
                ccwg_pkg::OP_AT_Y: yaw_reg     <= c_zo;
                ccwg_pkg::OP_SC_B: cb_reg      <= (c_xo < 0) ? 32'(-c_xo) : 32'(c_xo);
                ccwg_pkg::OP_SC_T: begin
                    ct_reg <= 32'(c_xo);
                    st_reg <= 32'(c_yo);
                end
                default: ;
            endcase
        end
        if (q_done)
            ru_reg <= q_root;
    end

    assign stat.arrive = acc_reg < t_reg;
    assign stat.done   = c_done || q_done;
    assign stat.busy   = c_busy || q_busy;
    assign m_data      = out_reg;
endmodule
`default_nettype wire

@@ rtl/core/carrot_chase_waypoint_guidance.sv @@
// Carrot-chase guidance over a closed loop of waypoints: top level.
// Depends on ccwg_pkg, ccwg_ctrl, ccwg_dp.
//
// s_* carries one odometry word (position Q8.8, quaternion Q1.14), m_* one
// command word (speed, turn rate, reached flag, segment), both valid/ready.
// cfg_we/cfg_index/cfg_wdata write the eight settings registers;
// write them only while the block is idle.
// One word is processed at a time. A word on arrival goes from the arrival
// test straight to the output step; any other word runs through six
// 16-step passes of the single CORDIC unit, one 18-step square root and
// 21 multiply/add steps on one shared multiplier, plus the output step.
// s_ready rises again as soon as the result sits in the output register,
// so the next word is taken while that result waits. If m_ready stays low,
// a finished second result holds in the sequencer until the output
// register frees up.
// Reset (aresetn low, synchronous) restores the default waypoint loop and
// gains, returns to segment 0 and drops m_valid.
`timescale 1ns / 1ps
`default_nettype none
module carrot_chase_waypoint_guidance #(
    parameter int NUM_WAYPOINTS = ccwg_pkg::DEF_NUM_WAYPOINTS
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire ccwg_pkg::in_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output ccwg_pkg::out_t       m_data,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [31:0]     cfg_wdata
);
    ccwg_pkg::cmd_t  cmd;
    ccwg_pkg::stat_t stat;

    ccwg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ccwg_dp #(
        .NUM_WAYPOINTS (NUM_WAYPOINTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    // one word in flight: no second acceptance straight after the first
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in work");

    // arrival words carry zero speeds
    a_arrival_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.reached |-> m_data.linear_speed == 16'd0 &&
        m_data.turn_rate == 16'sd0)
        else $error("arrival word with non-zero speed");

    // units are quiet whenever the sequencer is idle
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !stat.busy)
        else $error("arithmetic unit busy while idle");
endmodule
`default_nettype wire

@@ bench/carrot_chase_waypoint_guidance_tb.sv @@
// Self-checking bench for carrot_chase_waypoint_guidance: odometry words in,
// guidance command words checked against a bit-exact fixed-point predictor.
// Depends on ccwg_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module carrot_chase_waypoint_guidance_tb;

    localparam longint PI_FX = 205887;
    localparam longint TWO_PI_FX = 411775;
    localparam longint HALF_PI_FX = 102944;
    localparam longint UPSCALE = 16384;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    ccwg_pkg::in_t  s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    ccwg_pkg::out_t m_data;
    logic           cfg_we = 1'b0;
    logic [2:0]     cfg_index = ccwg_pkg::CFG_WP0;
    logic [31:0]    cfg_wdata = '0;

    carrot_chase_waypoint_guidance dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor copy of registers and segment state
    logic [31:0] wp_reg [4];
    logic [15:0] look_reg, gain_reg, speed_reg, radius_reg;
    logic [1:0]  seg_q;

    ccwg_pkg::out_t cmd_q [$];
    int   err_cnt = 0;
    int   words_sent = 0;
    int   words_checked = 0;
    int   arrivals = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;

    function automatic longint sx(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint wrap_fx(input longint a);
        if (a > PI_FX) return a - TWO_PI_FX;
        if (a < -PI_FX) return a + TWO_PI_FX;
        return a;
    endfunction

    function automatic longint atan_step(input int k);
        longint t [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};
        return t[k];
    endfunction

    function automatic longint atan2_fx(input longint yv, input longint xv);
        longint x, y, z, nx, ny;
        x = xv; y = yv; z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_FX : -PI_FX;
            x = -x;
            y = -y;
        end
        for (int k = 0; k < 16; k++) begin
            if (y > 0) begin
                nx = x + (y >>> k);
                ny = y - (x >>> k);
                z += atan_step(k);
            end else begin
                nx = x - (y >>> k);
                ny = y + (x >>> k);
                z -= atan_step(k);
            end
            x = nx;
            y = ny;
        end
        return wrap_fx(z);
    endfunction

    function automatic void sincos_fx(input longint za, output longint c, output longint s);
        longint x, y, z, nx, ny;
        bit flip;
        x = 652032874; y = 0; z = za; flip = 0;
        if (z > HALF_PI_FX) begin
            z -= PI_FX;
            flip = 1;
        end else if (z < -HALF_PI_FX) begin
            z += PI_FX;
            flip = 1;
        end
        for (int k = 0; k < 16; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                ny = y + (x >>> k);
                z -= atan_step(k);
            end else begin
                nx = x + (y >>> k);
                ny = y - (x >>> k);
                z += atan_step(k);
            end
            x = nx;
            y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint isqrt_fx(input longint unsigned n);
        longint unsigned res, b, m;
        res = 0; m = n; b = 64'd1 << 62;
        while (b > m) b >>= 2;
        while (b != 0) begin
            if (m >= res + b) begin
                m -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // one guidance update; advances seg_q on arrival
    function automatic ccwg_pkg::out_t guide(input ccwg_pkg::in_t w);
        ccwg_pkg::out_t o;
        longint px, py, qx, qy, qz, qw, xi, yi, xj, yj, dx, dy, rad;
        longint th_u, th, beta, cb, sb, ct, st, r, carrot_d, cx, cy, head, yaw, herr, turn;
        int i, j;
        px = sx(w.pos_x); py = sx(w.pos_y);
        qx = sx(w.quat_x); qy = sx(w.quat_y); qz = sx(w.quat_z); qw = sx(w.quat_w);
        i = seg_q;
        j = (i + 1) % 4;
        xi = sx(wp_reg[i][31:16]); yi = sx(wp_reg[i][15:0]);
        xj = sx(wp_reg[j][31:16]); yj = sx(wp_reg[j][15:0]);
        dx = px - xj;
        dy = py - yj;
        rad = longint'(radius_reg);
        if (dx * dx + dy * dy < rad * rad) begin
            seg_q = j[1:0];
            o.linear_speed = '0;
            o.turn_rate = '0;
            o.reached = 1'b1;
            o.segment = j[1:0];
            return o;
        end
        th_u = atan2_fx((yi - py) * UPSCALE, (xi - px) * UPSCALE);
        th = atan2_fx((yj - yi) * UPSCALE, (xj - xi) * UPSCALE);
        beta = wrap_fx(th - th_u);
        sincos_fx(beta, cb, sb);
        if (cb < 0) cb = -cb;
        r = (isqrt_fx((px - xi) * (px - xi) + (py - yi) * (py - yi)) * cb) >>> 30;
        sincos_fx(th, ct, st);
        carrot_d = r + longint'(look_reg);
        cx = ((carrot_d * ct) >>> 30) + xi;
        cy = ((carrot_d * st) >>> 30) + yi;
        head = atan2_fx((cy - py) * UPSCALE, (cx - px) * UPSCALE);
        yaw = atan2_fx(2 * (qw * qz + qx * qy), qw * qw + qx * qx - qy * qy - qz * qz);
        herr = wrap_fx(head - yaw);
        turn = (longint'(gain_reg) * herr) >>> 16;
        if (turn > 32767) turn = 32767;
        if (turn < -32768) turn = -32768;
        o.linear_speed = speed_reg;
        o.turn_rate = turn[15:0];
        o.reached = 1'b0;
        o.segment = seg_q;
        return o;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx <= ccwg_pkg::CFG_WP3) wp_reg[idx[1:0]] = val;
        else if (idx == ccwg_pkg::CFG_LOOKAHEAD) look_reg = val[15:0];
        else if (idx == ccwg_pkg::CFG_GAIN) gain_reg = val[15:0];
        else if (idx == ccwg_pkg::CFG_SPEED) speed_reg = val[15:0];
        else radius_reg = val[15:0];
    endtask

    task automatic send_word(input ccwg_pkg::in_t w);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) @(negedge aclk);
        s_valid = 1'b1;
        s_data = w;
        do @(posedge aclk); while (!s_ready);
        cmd_q.push_back(guide(w));
        words_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        while (cmd_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // words near the current segment, in a square around its end, or anywhere
    function automatic ccwg_pkg::in_t rand_word();
        ccwg_pkg::in_t w;
        int j, span;
        longint ax, ay, bx, by;
        j = (seg_q + 1) % 4;
        bx = sx(wp_reg[j][31:16]); by = sx(wp_reg[j][15:0]);
        ax = sx(wp_reg[seg_q][31:16]); ay = sx(wp_reg[seg_q][15:0]);
        span = int'(radius_reg);
        case ($urandom_range(9))
            0, 1, 2: begin
                if (span > 0) span = span - 1;
                w.pos_x = 16'(bx + $signed($urandom_range(2 * span)) - span);
                w.pos_y = 16'(by + $signed($urandom_range(2 * span)) - span);
            end
            3: begin
                w.pos_x = 16'($urandom);
                w.pos_y = 16'($urandom);
            end
            default: begin
                w.pos_x = 16'(ax + ((bx - ax) * longint'($urandom_range(16))) / 16
                              + $signed($urandom_range(512)) - 256);
                w.pos_y = 16'(ay + ((by - ay) * longint'($urandom_range(16))) / 16
                              + $signed($urandom_range(512)) - 256);
            end
        endcase
        w.quat_x = rand_quat();
        w.quat_y = rand_quat();
        w.quat_z = rand_quat();
        w.quat_w = rand_quat();
        return w;
    endfunction

    function automatic ccwg_pkg::in_t mk(input longint x, input longint y, input longint a,
                                         input longint b, input longint c, input longint d);
        ccwg_pkg::in_t w;
        w.pos_x = 16'(x); w.pos_y = 16'(y);
        w.quat_x = 16'(a); w.quat_y = 16'(b); w.quat_z = 16'(c); w.quat_w = 16'(d);
        return w;
    endfunction

    // result checker
    always @(posedge aclk) begin
        ccwg_pkg::out_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (cmd_q.size() == 0) begin
                $error("result word with nothing expected: %h", m_data);
                err_cnt++;
            end else begin
                exp_w = cmd_q.pop_front();
                words_checked++;
                if (m_data.reached) arrivals++;
                if (m_data.linear_speed !== exp_w.linear_speed) begin
                    $error("linear_speed exp %0d got %0d", exp_w.linear_speed,
                           m_data.linear_speed);
                    err_cnt++;
                end
                if (m_data.turn_rate !== exp_w.turn_rate) begin
                    $error("turn_rate exp %0d got %0d", exp_w.turn_rate, m_data.turn_rate);
                    err_cnt++;
                end
                if (m_data.reached !== exp_w.reached) begin
                    $error("reached exp %0d got %0d", exp_w.reached, m_data.reached);
                    err_cnt++;
                end
                if (m_data.segment !== exp_w.segment) begin
                    $error("segment exp %0d got %0d", exp_w.segment, m_data.segment);
                    err_cnt++;
                end
            end
        end
    end

    always @(negedge aclk) m_ready = ($urandom_range(99) >= stall_pct);

    task automatic test_directed();
        // arrive exactly on the first segment's end, then the next
        send_word(mk(-768, 384, 0, 0, 0, 16384));
        send_word(mk(-768, -384, 0, 0, 16384, 0));
        // robot on segment start: zero vector to start point
        send_word(mk(-768, -384, 0, 0, 0, 16384));
        // all-zero quaternion, non-unit quaternion, extremes
        send_word(mk(0, 0, 0, 0, 0, 0));
        send_word(mk(100, -50, 16384, 16384, 16384, 16384));
        send_word(mk(100, -50, -16384, -16384, -16384, -16384));
        send_word(mk(-32768, -32768, 16384, -16384, 16384, -16384));
        send_word(mk(32767, 32767, -16384, 16384, -16384, 16384));
        send_word(mk(32767, -32768, 1, -1, 8192, -8192));
        send_word(mk(-32768, 32767, 0, 0, -16384, 1));
        // just outside and just inside the arrival radius of (-3,-1.5)->(4,-1.5)
        send_word(mk(1024 - 26, -384, 0, 0, 0, 16384));
        send_word(mk(1024 - 25, -384, 0, 0, 0, 16384));
        send_word(mk(1024, 384 - 25, 0, 0, 0, 16384));
        drain();
        // zero-length segment: both words arrive, the second at its end
        write_reg(ccwg_pkg::CFG_WP1, 32'h0100_0100);
        write_reg(ccwg_pkg::CFG_WP2, 32'h0100_0100);
        send_word(mk(256, 256, 0, 0, 0, 16384));
        send_word(mk(256, 257, 0, 0, 0, 16384));
        drain();
    endtask

    task automatic test_config_extremes();
        logic [31:0] wset [4];
        wset = '{32'h8000_8000, 32'h7FFF_7FFF, 32'h7FFF_8000, 32'h8000_7FFF};
        for (int p = 0; p < 4; p++) begin
            for (int k = 0; k < 4; k++) write_reg(3'(k), wset[(k + p) % 4]);
            write_reg(ccwg_pkg::CFG_LOOKAHEAD, p[0] ? 32'h0000_FFFF : 32'h0);
            write_reg(ccwg_pkg::CFG_GAIN, p[1] ? 32'h0000_FFFF : 32'h0);
            write_reg(ccwg_pkg::CFG_SPEED, p[0] ? 32'h0 : 32'h0000_FFFF);
            write_reg(ccwg_pkg::CFG_RADIUS, (p == 3) ? 32'h0000_FFFF : 32'h0);
            for (int n = 0; n < 5; n++) send_word(rand_word());
            drain();
        end
    endtask

    task automatic test_random(input int n_words, input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
        for (int k = 0; k < 4; k++) write_reg(3'(k), $urandom);
        if ($urandom_range(1)) begin
            // small loop so arrivals happen often
            for (int k = 0; k < 4; k++)
                write_reg(3'(k), {16'($signed($urandom_range(4096)) - 2048),
                                  16'($signed($urandom_range(4096)) - 2048)});
        end
        write_reg(ccwg_pkg::CFG_LOOKAHEAD, $urandom_range(1023));
        write_reg(ccwg_pkg::CFG_GAIN,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(2047));
        write_reg(ccwg_pkg::CFG_SPEED, $urandom);
        write_reg(ccwg_pkg::CFG_RADIUS,
                  $urandom_range(4) == 0 ? $urandom : $urandom_range(300));
        for (int n = 0; n < n_words; n++) send_word(rand_word());
        drain();
    endtask

    initial begin
        wp_reg = '{32'd67109248, 32'd4244636032, 32'd4244700800, 32'd67174016};
        look_reg = 16'd128;
        gain_reg = 16'd256;
        speed_reg = 16'd51;
        radius_reg = 16'd26;
        seg_q = 2'd0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_config_extremes();
        test_random(110, 0, 0);
        test_random(100, 75, 0);
        test_random(100, 0, 75);
        test_random(100, 21, 21);
        idle_pct = 0;
        stall_pct = 0;
        drain();
        if (cmd_q.size() != 0) begin
            $error("%0d expected words never arrived", cmd_q.size());
            err_cnt++;
        end
        $display("Sent %0d odometry words, checked %0d commands, %0d of them arrivals,",
                 words_sent, words_checked, arrivals);
        $display("over default, extreme and random waypoint loops and four handshake phases.");
        if (err_cnt == 0) begin
            $display("[carrot_chase_waypoint_guidance] OK");
        end else begin
            $display("[carrot_chase_waypoint_guidance] ERROR");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("[carrot_chase_waypoint_guidance] ERROR");
        $finish;
    end

endmodule
